// ===== hdl/lhcbf_pkg.sv =====
// Shared types, codes and constants of the light hue cycle and beat flash block.
package lhcbf_pkg;

  // input event codes
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_FAST = 2'd1;
  localparam logic [1:0] MODE_SLOW = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_TICK_HUE_STEP   = 3'd0;
  localparam logic [2:0] REG_BEAT_HUE_STEP   = 3'd1;
  localparam logic [2:0] REG_HUE_START       = 3'd2;
  localparam logic [2:0] REG_HUE_END         = 3'd3;
  localparam logic [2:0] REG_BRIGHTNESS_SLEW = 3'd4;

  // reset values
  localparam logic [15:0] RST_TICK_HUE_STEP   = 16'd3000;
  localparam logic [15:0] RST_BEAT_HUE_STEP   = 16'd1500;
  localparam logic [15:0] RST_HUE_START       = 16'd0;
  localparam logic [15:0] RST_HUE_END         = 16'd46920;
  localparam logic [7:0]  RST_BRIGHTNESS_SLEW = 8'd7;
  localparam logic [7:0]  RST_BRIGHTNESS      = 8'd75;

  // command constants
  localparam logic [7:0] FADE_BRIGHTNESS = 8'd5;
  localparam logic [3:0] TR_TICK  = 4'd10;
  localparam logic [3:0] TR_FAST0 = 4'd0;
  localparam logic [3:0] TR_FAST1 = 4'd10;
  localparam logic [3:0] TR_SLOW0 = 4'd2;
  localparam logic [3:0] TR_SLOW1 = 4'd8;

  // hue to rgb constants
  localparam logic [16:0] HUE_SECTOR = 17'd65535;
  localparam logic [16:0] RISE_ROUND = 17'd128;
  localparam logic [24:0] RISE_DIV   = 25'd257;
  localparam logic [2:0]  LAST_SECTOR = 3'd5;

  // command queue depth
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_FAST,
    KIND_SLOW
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  bri;      // brightness of the first command
    logic [15:0] hue;      // commanded hue
    logic [15:0] rgb_hue;  // hue the colour is taken from
  } cmd_t;

endpackage

// ===== hdl/lhcbf_fifo.sv =====
// Short command queue between the event front end and the command back end.
module lhcbf_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lhcbf_pkg::cmd_t    din,
  output logic               full,
  input  logic               pop,
  output logic               nonempty,
  output lhcbf_pkg::cmd_t    dout
);

  lhcbf_pkg::cmd_t mem_r [lhcbf_pkg::QUEUE_DEPTH];
  logic [lhcbf_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lhcbf_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lhcbf_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full     = (count_r == lhcbf_pkg::QCNT_W'(lhcbf_pkg::QUEUE_DEPTH));
  assign nonempty = (count_r != '0);
  assign dout     = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == lhcbf_pkg::QPTR_W'(lhcbf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == lhcbf_pkg::QPTR_W'(lhcbf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hdl/lhcbf_front.sv =====
// Front end: takes events, holds the hue and brightness state and queues commands.
module lhcbf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [7:0]        in_target_brightness,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output lhcbf_pkg::cmd_t   q_din
);

  logic [15:0] tick_step_r, beat_step_r;
  logic [7:0]  slew_r;
  logic [15:0] cur_hue_r, head_hue_r, ret_hue_r;
  logic [7:0]  cur_bri_r;

  logic [15:0] cur_hue_nxt, head_hue_nxt, ret_hue_nxt;
  logic [7:0]  cur_bri_nxt;
  logic        accept, known;
  logic [15:0] step, gap;
  logic signed [8:0] bri_diff, slew_s;
  logic [8:0]  boost;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign known    = (in_mode == lhcbf_pkg::MODE_TICK) || (in_mode == lhcbf_pkg::MODE_FAST) ||
                    (in_mode == lhcbf_pkg::MODE_SLOW);
  assign q_push   = accept && known;

  always_comb begin
    step = (in_mode == lhcbf_pkg::MODE_TICK) ? tick_step_r : beat_step_r;
    gap  = (cur_hue_r > head_hue_r) ? cur_hue_r - head_hue_r : head_hue_r - cur_hue_r;

    // hue step toward heading for tick and fast events; swap ends on arrival
    cur_hue_nxt  = cur_hue_r;
    head_hue_nxt = head_hue_r;
    ret_hue_nxt  = ret_hue_r;
    if (in_mode != lhcbf_pkg::MODE_SLOW) begin
      if (gap > step) begin
        cur_hue_nxt = (cur_hue_r > head_hue_r) ? cur_hue_r - step : cur_hue_r + step;
      end else begin
        cur_hue_nxt  = head_hue_r;
        head_hue_nxt = ret_hue_r;
        ret_hue_nxt  = head_hue_r;
      end
    end

    // brightness slew
    bri_diff = $signed({1'b0, cur_bri_r}) - $signed({1'b0, in_target_brightness});
    slew_s   = $signed({1'b0, slew_r});
    if (bri_diff > slew_s) begin
      cur_bri_nxt = cur_bri_r - slew_r;
    end else if (bri_diff < -slew_s) begin
      cur_bri_nxt = cur_bri_r + slew_r;
    end else begin
      cur_bri_nxt = in_target_brightness;
    end

    boost = '0;
    q_din = '0;
    case (in_mode)
      lhcbf_pkg::MODE_TICK: begin
        q_din.kind    = lhcbf_pkg::KIND_TICK;
        q_din.bri     = cur_bri_nxt;
        q_din.hue     = cur_hue_nxt;
        q_din.rgb_hue = cur_hue_nxt;
      end
      lhcbf_pkg::MODE_FAST: begin
        boost         = {1'b0, cur_bri_nxt} + {2'b00, cur_bri_nxt[7:1]};
        q_din.kind    = lhcbf_pkg::KIND_FAST;
        q_din.bri     = boost[8] ? 8'hFF : boost[7:0];
        q_din.hue     = cur_hue_r;
        q_din.rgb_hue = cur_hue_nxt;
      end
      lhcbf_pkg::MODE_SLOW: begin
        boost         = {1'b0, cur_bri_nxt} + {3'b000, cur_bri_nxt[7:2]};
        q_din.kind    = lhcbf_pkg::KIND_SLOW;
        q_din.bri     = boost[8] ? 8'hFF : boost[7:0];
        q_din.hue     = cur_hue_r;
        q_din.rgb_hue = cur_hue_r;
      end
      default: begin
        q_din = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_step_r <= lhcbf_pkg::RST_TICK_HUE_STEP;
      beat_step_r <= lhcbf_pkg::RST_BEAT_HUE_STEP;
      slew_r      <= lhcbf_pkg::RST_BRIGHTNESS_SLEW;
      cur_hue_r   <= lhcbf_pkg::RST_HUE_START;
      head_hue_r  <= lhcbf_pkg::RST_HUE_END;
      ret_hue_r   <= lhcbf_pkg::RST_HUE_START;
      cur_bri_r   <= lhcbf_pkg::RST_BRIGHTNESS;
    end else if (cfg_we) begin
      case (cfg_index)
        lhcbf_pkg::REG_TICK_HUE_STEP:   tick_step_r <= cfg_data;
        lhcbf_pkg::REG_BEAT_HUE_STEP:   beat_step_r <= cfg_data;
        lhcbf_pkg::REG_HUE_START: begin
          cur_hue_r <= cfg_data;
          ret_hue_r <= cfg_data;
        end
        lhcbf_pkg::REG_HUE_END:         head_hue_r <= cfg_data;
        lhcbf_pkg::REG_BRIGHTNESS_SLEW: slew_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end else if (q_push) begin
      cur_hue_r  <= cur_hue_nxt;
      head_hue_r <= head_hue_nxt;
      ret_hue_r  <= ret_hue_nxt;
      cur_bri_r  <= cur_bri_nxt;
    end
  end

endmodule

// ===== hdl/lhcbf_back.sv =====
// Back end: hue to rgb in two stages, stage A and the output register that emits the commands.
module lhcbf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_nonempty,
  input  lhcbf_pkg::cmd_t   q_dout,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_brightness,
  output logic [15:0]       out_hue,
  output logic [3:0]        out_transition,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic              out_last
);

  // stage A: sector and remainder
  logic            a_valid_r, a_valid_nxt;
  lhcbf_pkg::cmd_t a_cmd_r;
  logic [2:0]      a_sec_r, a_sec_nxt;
  logic [15:0]     a_rem_r, a_rem_nxt;

  // output register
  logic            o_valid_r, o_valid_nxt;
  lhcbf_pkg::kind_t o_kind_r;
  logic [7:0]      o_bri_r;
  logic [15:0]     o_hue_r;
  logic [3:0]      o_tr_r;
  logic [7:0]      o_red_r, o_green_r, o_blue_r;
  logic            o_last_r;

  logic        out_fire, b_load;
  logic [18:0] s6;
  logic [16:0] rem_g;
  logic [16:0] x;
  logic [24:0] x255, q_prod, q_rem;
  logic [7:0]  q0, rise, fall;
  logic [7:0]  red_n, green_n, blue_n;
  logic [3:0]  tr0;

  assign out_fire = o_valid_r && out_ready;
  assign b_load   = a_valid_r && (!o_valid_r || (out_fire && o_last_r));
  assign q_pop    = q_nonempty && (!a_valid_r || b_load);
  assign a_valid_nxt = q_pop || (a_valid_r && !b_load);

  // sector = hue*6 / 65535 with one correction step
  always_comb begin
    s6    = {1'b0, q_dout.rgb_hue, 2'b00} + {2'b00, q_dout.rgb_hue, 1'b0};
    rem_g = {1'b0, s6[15:0]} + {14'd0, s6[18:16]};
    if (rem_g >= lhcbf_pkg::HUE_SECTOR) begin
      a_sec_nxt = s6[18:16] + 3'd1;
      a_rem_nxt = 16'(rem_g - lhcbf_pkg::HUE_SECTOR);
    end else begin
      a_sec_nxt = s6[18:16];
      a_rem_nxt = rem_g[15:0];
    end
  end

  // rising channel: (rem + 128) / 257 via reciprocal and one correction
  always_comb begin
    x      = {1'b0, a_rem_r} + lhcbf_pkg::RISE_ROUND;
    x255   = {x, 8'd0} - {8'd0, x};
    q0     = x255[23:16];
    q_prod = {9'd0, q0, 8'd0} + {17'd0, q0};
    q_rem  = {8'd0, x} - q_prod;
    rise   = (q_rem >= lhcbf_pkg::RISE_DIV) ? q0 + 8'd1 : q0;
    fall   = 8'hFF - rise;
    case (a_sec_r)
      3'd0:    begin red_n = 8'hFF; green_n = rise;  blue_n = 8'h00; end
      3'd1:    begin red_n = fall;  green_n = 8'hFF; blue_n = 8'h00; end
      3'd2:    begin red_n = 8'h00; green_n = 8'hFF; blue_n = rise;  end
      3'd3:    begin red_n = 8'h00; green_n = fall;  blue_n = 8'hFF; end
      3'd4:    begin red_n = rise;  green_n = 8'h00; blue_n = 8'hFF; end
      3'd5:    begin red_n = 8'hFF; green_n = 8'h00; blue_n = fall;  end
      3'd6:    begin red_n = 8'hFF; green_n = rise;  blue_n = 8'h00; end
      default: begin red_n = 8'hFF; green_n = rise;  blue_n = 8'h00; end
    endcase
    case (a_cmd_r.kind)
      lhcbf_pkg::KIND_TICK: tr0 = lhcbf_pkg::TR_TICK;
      lhcbf_pkg::KIND_FAST: tr0 = lhcbf_pkg::TR_FAST0;
      lhcbf_pkg::KIND_SLOW: tr0 = lhcbf_pkg::TR_SLOW0;
      default:              tr0 = lhcbf_pkg::TR_TICK;
    endcase
  end

  always_comb begin
    o_valid_nxt = o_valid_r;
    if (b_load) begin
      o_valid_nxt = 1'b1;
    end else if (out_fire && o_last_r) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_cmd_r <= q_dout;
      a_sec_r <= a_sec_nxt;
      a_rem_r <= a_rem_nxt;
    end
    if (b_load) begin
      o_kind_r  <= a_cmd_r.kind;
      o_bri_r   <= a_cmd_r.bri;
      o_hue_r   <= a_cmd_r.hue;
      o_tr_r    <= tr0;
      o_red_r   <= red_n;
      o_green_r <= green_n;
      o_blue_r  <= blue_n;
      o_last_r  <= (a_cmd_r.kind == lhcbf_pkg::KIND_TICK);
    end else if (out_fire && !o_last_r) begin
      // advance to the fade command of a beat
      o_bri_r  <= lhcbf_pkg::FADE_BRIGHTNESS;
      o_tr_r   <= (o_kind_r == lhcbf_pkg::KIND_SLOW) ? lhcbf_pkg::TR_SLOW1 :
                                                        lhcbf_pkg::TR_FAST1;
      o_last_r <= 1'b1;
    end
  end

  assign out_valid      = o_valid_r;
  assign out_brightness = o_bri_r;
  assign out_hue        = o_hue_r;
  assign out_transition = o_tr_r;
  assign out_red        = o_red_r;
  assign out_green      = o_green_r;
  assign out_blue       = o_blue_r;
  assign out_last       = o_last_r;

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> (a_sec_r <= lhcbf_pkg::LAST_SECTOR + 3'd1) && (a_rem_r != 16'hFFFF))
    else $error("hue sector or remainder out of range");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !b_load) |=> (a_valid_r && $stable(a_rem_r) && $stable(a_sec_r)))
    else $error("stage A lost an item while stalled");

  a_fade_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !o_last_r) |=> (o_valid_r && o_last_r &&
                                 o_bri_r == lhcbf_pkg::FADE_BRIGHTNESS))
    else $error("beat flash not followed by its fade command");

  a_tick_single: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_kind_r == lhcbf_pkg::KIND_TICK) |-> o_last_r)
    else $error("tick produced more than one command");

endmodule

// ===== hdl/light_hue_cycle_and_beat_flash.sv =====
// Top level of the light hue cycle and beat flash controller.
//
// Events enter on the in_ channel (mode, target brightness) under valid/ready.
// The front end updates hue and brightness state in the cycle an event is
// accepted and drops a command into a four-entry queue; the back end turns
// each command into one result (tick) or two (beat flash and fade) on the
// out_ channel, also valid/ready. Mode 3 is accepted and produces nothing.
// An event's command passes through the queue, stage A and the output register
// before it is offered. Throughput: one tick per cycle while out_ready is high;
// a beat holds the output register until both of its commands are taken.
// When the receiver stalls the output register holds its command, the hue
// to rgb stage and the queue fill, and in_ready drops once the queue is full.
// Reset (synchronous, rst_n low) restores the register defaults, hue 0
// heading toward 46920, brightness 75, and empties the queue and pipeline.
// Configuration writes on cfg_ take effect at once and belong to idle time;
// a write to hue_start or hue_end reloads the hue state.
module light_hue_cycle_and_beat_flash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_target_brightness,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_brightness,
  output logic [15:0] out_hue,
  output logic [3:0]  out_transition,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic            q_full, q_push, q_pop, q_nonempty;
  lhcbf_pkg::cmd_t q_din, q_dout;

  lhcbf_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_target_brightness (in_target_brightness),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_din                (q_din)
  );

  lhcbf_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .din      (q_din),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .dout     (q_dout)
  );

  lhcbf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_nonempty     (q_nonempty),
    .q_dout         (q_dout),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_brightness (out_brightness),
    .out_hue        (out_hue),
    .out_transition (out_transition),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_last       (out_last)
  );

endmodule
